// ===== hdl/rmn_pkg.sv =====
// ----------------------------------------------------------------------------
// rmn_pkg - shared types and constants for the regret matching node
// Field widths, fixed-point constants and request kind codes.
// ----------------------------------------------------------------------------
package rmn_pkg;

	localparam int ACTION_CNT_DEF = 2;

	localparam int ACTION_W = 1;   // action index field
	localparam int REGRET_W = 32;  // signed Q16.16 regret
	localparam int PROB_W   = 17;  // Q1.16 probability, 65536 is one
	localparam int ACC_W    = 48;  // accumulator width
	localparam int DIG_W    = 4;   // serial adder digit

	localparam int ONE_INT = 65536;
	localparam logic [PROB_W-1:0] ONE_Q16 = PROB_W'(ONE_INT);

	typedef enum logic [1:0] {
		KIND_ADD_REGRET   = 2'd0,
		KIND_ADD_STRATEGY = 2'd1,
		KIND_READ_CURRENT = 2'd2,
		KIND_READ_AVERAGE = 2'd3
	} kind_t;

endpackage

// ===== hdl/regret_matching_node.sv =====
// ----------------------------------------------------------------------------
// regret_matching_node - one regret matching decision node
// Holds a saturating cumulative regret and cumulative strategy per action,
// updates them with a digit-serial adder and reads normalized strategies
// through a bit-serial restoring divider.
// ----------------------------------------------------------------------------
//
// Channel   Signals                                        Handshake
// -------   --------------------------------------------   -----------------------
// request   kind, action, regret, strategy_share, weight   start && !busy
// result    out_action, probability, last_of_run          strobe, one cycle, no stall
//
// An add-regret request keeps busy high while the 4-bit serial adder works
//   through the 48 bits digit by digit and then writes back; an add-strategy
//   request first does the 17x17 multiply.
// A read first sums the divisor over all actions, then per action loads the
//   operand and runs the serial divider for 17 quotient bits; with a zero
//   divisor each action gets the uniform share instead.
// Reset clears both accumulator arrays and all control state at once.
// Results come out with strobe for one cycle each and cannot be held off.
//
module regret_matching_node #(
	parameter int ACTION_CNT = rmn_pkg::ACTION_CNT_DEF
) (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic                               start,
	output logic                               busy,
	input  rmn_pkg::kind_t                     kind,
	input  logic [rmn_pkg::ACTION_W-1:0]       action,
	input  logic signed [rmn_pkg::REGRET_W-1:0] regret,
	input  logic [rmn_pkg::PROB_W-1:0]         strategy_share,
	input  logic [rmn_pkg::PROB_W-1:0]         weight,
	output logic                               strobe,
	output logic [rmn_pkg::ACTION_W-1:0]       out_action,
	output logic [rmn_pkg::PROB_W-1:0]         probability,
	output logic                               last_of_run
);
	import rmn_pkg::*;

	localparam int IDX_W  = $clog2(ACTION_CNT);
	localparam int SUM_W  = ACC_W + IDX_W;       // sum of all values never overflows
	localparam int REM_W  = SUM_W + 1;           // remainder after a left shift
	localparam int PROD_W = 2 * PROB_W;
	localparam int NDIG   = ACC_W / DIG_W;
	localparam int DCNT_W = $clog2(NDIG);
	localparam int BCNT_W = $clog2(PROB_W);
	localparam logic [IDX_W-1:0]  LAST_IDX = IDX_W'(ACTION_CNT - 1);
	localparam logic [PROB_W-1:0] UNIFORM  = PROB_W'(ONE_INT / ACTION_CNT);
	localparam logic [ACC_W-1:0]  REG_MAX  = {1'b0, {(ACC_W-1){1'b1}}};
	localparam logic [ACC_W-1:0]  REG_MIN  = {1'b1, {(ACC_W-1){1'b0}}};

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_MUL,
		ST_ADD,
		ST_WRITE,
		ST_SUM,
		ST_LOAD,
		ST_DIV
	} state_t;

	state_t               state_q;
	kind_t                kind_q;
	logic [IDX_W-1:0]     idx_q;
	logic [PROB_W-1:0]    sh_q, w_q;

	// serial adder: operands shift right a digit per cycle, sum shifts in on top
	logic [ACC_W-1:0]     opa_q, opb_q, res_q;
	logic                 sa_q, sb_q, carry_q;
	logic [DCNT_W-1:0]    dcnt_q;

	// divider
	logic [SUM_W-1:0]     sum_q;
	logic [REM_W-1:0]     rem_q;
	logic [PROB_W-1:0]    quo_q;
	logic [BCNT_W-1:0]    bcnt_q;

	logic                 strobe_q, last_q;
	logic [ACTION_W-1:0]  out_action_q;
	logic [PROB_W-1:0]    prob_q;

	logic [ACC_W-1:0]     creg_q [ACTION_CNT];  // two's complement regret sums
	logic [ACC_W-1:0]     cstr_q [ACTION_CNT];  // unsigned strategy sums

	logic [IDX_W-1:0]     act_idx;
	logic                 act_ok;
	logic [PROD_W-1:0]    prod;
	logic [ACC_W-1:0]     val;
	logic [DIG_W:0]       dsum;
	logic                 reg_ovf;
	logic [REM_W-1:0]     trial, den_ext, diff;
	logic                 ge;
	logic                 last_idx;

	assign act_idx = IDX_W'(action);
	assign act_ok  = int'(action) < ACTION_CNT;
	assign prod    = PROD_W'(sh_q) * PROD_W'(w_q);

	// value of the action under read: positive part of regret, or strategy sum
	always_comb begin
		if (kind_q == KIND_READ_CURRENT) begin
			val = creg_q[idx_q][ACC_W-1] ? '0 : creg_q[idx_q];
		end else begin
			val = cstr_q[idx_q];
		end
	end

	assign dsum = {1'b0, opa_q[DIG_W-1:0]} + {1'b0, opb_q[DIG_W-1:0]}
		+ (DIG_W+1)'(carry_q);
	// signed overflow: equal operand signs, result sign differs
	assign reg_ovf = (sa_q == sb_q) && (res_q[ACC_W-1] != sa_q);

	// restoring divide step; the first step compares without a shift
	assign trial   = (bcnt_q == '0) ? rem_q : {rem_q[REM_W-2:0], 1'b0};
	assign den_ext = {1'b0, sum_q};
	assign ge      = trial >= den_ext;
	assign diff    = trial - den_ext;
	assign last_idx = idx_q == LAST_IDX;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= ST_IDLE;
			kind_q       <= KIND_ADD_REGRET;
			idx_q        <= '0;
			sh_q         <= '0;
			w_q          <= '0;
			opa_q        <= '0;
			opb_q        <= '0;
			res_q        <= '0;
			sa_q         <= 1'b0;
			sb_q         <= 1'b0;
			carry_q      <= 1'b0;
			dcnt_q       <= '0;
			sum_q        <= '0;
			rem_q        <= '0;
			quo_q        <= '0;
			bcnt_q       <= '0;
			strobe_q     <= 1'b0;
			last_q       <= 1'b0;
			out_action_q <= '0;
			prob_q       <= '0;
			for (int i = 0; i < ACTION_CNT; i++) begin
				creg_q[i] <= '0;
				cstr_q[i] <= '0;
			end
		end else begin
			strobe_q <= 1'b0;
			unique case (state_q)
				ST_IDLE: begin
					if (start) begin
						kind_q  <= kind;
						carry_q <= 1'b0;
						dcnt_q  <= '0;
						unique case (kind)
							KIND_ADD_REGRET: begin
								idx_q <= act_idx;
								opa_q <= ACC_W'(regret);
								opb_q <= creg_q[act_idx];
								sa_q  <= regret[REGRET_W-1];
								sb_q  <= creg_q[act_idx][ACC_W-1];
								if (act_ok) begin
									state_q <= ST_ADD;
								end
							end
							KIND_ADD_STRATEGY: begin
								idx_q <= act_idx;
								sh_q  <= (strategy_share > ONE_Q16) ? ONE_Q16 : strategy_share;
								w_q   <= (weight > ONE_Q16) ? ONE_Q16 : weight;
								if (act_ok) begin
									state_q <= ST_MUL;
								end
							end
							KIND_READ_CURRENT, KIND_READ_AVERAGE: begin
								idx_q   <= '0;
								sum_q   <= '0;
								state_q <= ST_SUM;
							end
							default: begin
								state_q <= ST_IDLE;
							end
						endcase
					end
				end
				ST_MUL: begin
					opa_q   <= ACC_W'(prod);
					opb_q   <= cstr_q[idx_q];
					state_q <= ST_ADD;
				end
				ST_ADD: begin
					opa_q   <= opa_q >> DIG_W;
					opb_q   <= opb_q >> DIG_W;
					res_q   <= {dsum[DIG_W-1:0], res_q[ACC_W-1:DIG_W]};
					carry_q <= dsum[DIG_W];
					if (dcnt_q == DCNT_W'(NDIG - 1)) begin
						state_q <= ST_WRITE;
					end else begin
						dcnt_q <= dcnt_q + DCNT_W'(1);
					end
				end
				ST_WRITE: begin
					if (kind_q == KIND_ADD_REGRET) begin
						creg_q[idx_q] <= reg_ovf ? (sa_q ? REG_MIN : REG_MAX) : res_q;
					end else begin
						// carry out of the unsigned add means saturation
						cstr_q[idx_q] <= carry_q ? '1 : res_q;
					end
					state_q <= ST_IDLE;
				end
				ST_SUM: begin
					sum_q <= sum_q + SUM_W'(val);
					if (last_idx) begin
						idx_q   <= '0;
						state_q <= ST_LOAD;
					end else begin
						idx_q <= idx_q + IDX_W'(1);
					end
				end
				ST_LOAD: begin
					if (sum_q == '0) begin
						strobe_q     <= 1'b1;
						prob_q       <= UNIFORM;
						out_action_q <= ACTION_W'(idx_q[0]);
						last_q       <= last_idx;
						if (last_idx) begin
							state_q <= ST_IDLE;
						end else begin
							idx_q <= idx_q + IDX_W'(1);
						end
					end else begin
						rem_q   <= REM_W'(val);
						quo_q   <= '0;
						bcnt_q  <= '0;
						state_q <= ST_DIV;
					end
				end
				ST_DIV: begin
					rem_q <= ge ? diff : trial;
					quo_q <= {quo_q[PROB_W-2:0], ge};
					if (bcnt_q == BCNT_W'(PROB_W - 1)) begin
						strobe_q     <= 1'b1;
						prob_q       <= {quo_q[PROB_W-2:0], ge};
						out_action_q <= ACTION_W'(idx_q[0]);
						last_q       <= last_idx;
						if (last_idx) begin
							state_q <= ST_IDLE;
						end else begin
							idx_q   <= idx_q + IDX_W'(1);
							state_q <= ST_LOAD;
						end
					end else begin
						bcnt_q <= bcnt_q + BCNT_W'(1);
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	assign busy        = state_q != ST_IDLE;
	assign strobe      = strobe_q;
	assign out_action  = out_action_q;
	assign probability = prob_q;
	assign last_of_run = last_q;

	// a freshly accepted request never yields a result in the next cycle
	a_no_early_result: assert property (@(posedge clk) disable iff (!arst_n)
		start && !busy |=> !strobe)
		else $error("result right after request accept");

	// results of a read stay apart from the next read
	a_gap_after_last: assert property (@(posedge clk) disable iff (!arst_n)
		strobe && last_of_run |=> !strobe)
		else $error("result after last of run");

	// a read is still in progress until its last result
	a_busy_mid_run: assert property (@(posedge clk) disable iff (!arst_n)
		strobe && !last_of_run |-> busy)
		else $error("idle in the middle of a read");

	// a probability never exceeds one
	a_prob_range: assert property (@(posedge clk) disable iff (!arst_n)
		strobe |-> probability <= ONE_Q16)
		else $error("probability above one");

endmodule

// ===== sim/rmn_checker.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rmn_checker - scoreboard for the regret matching node
// Tracks every accepted request, keeps its own regret and strategy sums,
// predicts the probabilities of each read and compares them with the
// results in order.
// ----------------------------------------------------------------------------
module rmn_checker #(
	parameter int ACTION_CNT = rmn_pkg::ACTION_CNT_DEF
) (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                start,
	input  logic                                busy,
	input  rmn_pkg::kind_t                      kind,
	input  logic [rmn_pkg::ACTION_W-1:0]        action,
	input  logic signed [rmn_pkg::REGRET_W-1:0] regret,
	input  logic [rmn_pkg::PROB_W-1:0]          strategy_share,
	input  logic [rmn_pkg::PROB_W-1:0]          weight,
	input  logic                                strobe,
	input  logic [rmn_pkg::ACTION_W-1:0]        out_action,
	input  logic [rmn_pkg::PROB_W-1:0]          probability,
	input  logic                                last_of_run,
	output int                                  mismatch_count,
	output int                                  results_pending
);
	import rmn_pkg::*;

	localparam longint REGRET_CEIL  = (longint'(1) << (ACC_W-1)) - 1;
	localparam longint REGRET_FLOOR = -REGRET_CEIL - 1;
	localparam int     SCALED_W     = ACC_W + PROB_W + 8;

	typedef struct packed {
		logic [ACTION_W-1:0] act;
		logic [PROB_W-1:0]   prob;
		logic                last;
	} prob_result_t;

	logic signed [ACC_W-1:0] regret_sum [ACTION_CNT];
	logic [ACC_W-1:0]        play_sum [ACTION_CNT];
	prob_result_t            probs_due [$];

	task automatic report_mismatch(input string what);
		$display("[%0t] rmn mismatch: %s", $realtime, what);
		mismatch_count++;
	endtask

	// Applies one request to the local sums; reads queue one result per action.
	task automatic apply_request(input kind_t k, input logic [ACTION_W-1:0] act,
			input logic signed [REGRET_W-1:0] rg, input logic [PROB_W-1:0] share,
			input logic [PROB_W-1:0] wt);
		longint                sum_r;
		logic [ACC_W:0]        sum_s;
		logic [PROB_W-1:0]     sh;
		logic [PROB_W-1:0]     w;
		logic [2*PROB_W-1:0]   prod;
		logic [ACC_W-1:0]      part [ACTION_CNT];
		logic [ACC_W+4:0]      total;
		logic [SCALED_W-1:0]   scaled;
		logic [PROB_W-1:0]     prob;
		prob_result_t          item;

		case (k)
			KIND_ADD_REGRET: begin
				if (act < ACTION_CNT) begin
					sum_r = longint'(regret_sum[act]) + longint'(rg);
					if (sum_r > REGRET_CEIL)
						sum_r = REGRET_CEIL;
					else if (sum_r < REGRET_FLOOR)
						sum_r = REGRET_FLOOR;
					regret_sum[act] = sum_r[ACC_W-1:0];
				end
			end
			KIND_ADD_STRATEGY: begin
				if (act < ACTION_CNT) begin
					// shares and weights above one clamp to one
					sh = (share > ONE_Q16) ? ONE_Q16 : share;
					w = (wt > ONE_Q16) ? ONE_Q16 : wt;
					prod = (2*PROB_W)'(sh) * (2*PROB_W)'(w);
					sum_s = {1'b0, play_sum[act]} + (ACC_W+1)'(prod);
					play_sum[act] = sum_s[ACC_W] ? '1 : sum_s[ACC_W-1:0];
				end
			end
			default: begin
				total = '0;
				for (int a = 0; a < ACTION_CNT; a++) begin
					if (k == KIND_READ_CURRENT)
						part[a] = (regret_sum[a] > 0) ? regret_sum[a] : '0;
					else
						part[a] = play_sum[a];
					total = total + (ACC_W+5)'(part[a]);
				end
				for (int a = 0; a < ACTION_CNT; a++) begin
					if (total == 0) begin
						prob = PROB_W'(ONE_INT / ACTION_CNT);
					end else begin
						scaled = SCALED_W'(part[a]);
						scaled = (scaled << 16) / SCALED_W'(total);
						prob = scaled[PROB_W-1:0];
					end
					item.act = ACTION_W'(a);
					item.prob = prob;
					item.last = (a == ACTION_CNT - 1);
					probs_due.push_back(item);
				end
			end
		endcase
	endtask

	always @(posedge clk or negedge arst_n) begin
		prob_result_t want;

		if (!arst_n) begin
			for (int a = 0; a < ACTION_CNT; a++) begin
				regret_sum[a] = '0;
				play_sum[a] = '0;
			end
			probs_due.delete();
			mismatch_count = 0;
			results_pending = 0;
		end else begin
			if (strobe) begin
				if (probs_due.size() == 0) begin
					report_mismatch($sformatf("unexpected result action %0d probability %0d",
						out_action, probability));
				end else begin
					want = probs_due.pop_front();
					if (out_action !== want.act)
						report_mismatch($sformatf("out_action %0d, want %0d",
							out_action, want.act));
					if (probability !== want.prob)
						report_mismatch($sformatf("action %0d probability %0d, want %0d",
							want.act, probability, want.prob));
					if (last_of_run !== want.last)
						report_mismatch($sformatf("action %0d last_of_run %0b, want %0b",
							want.act, last_of_run, want.last));
				end
			end
			if (start && !busy)
				apply_request(kind, action, regret, strategy_share, weight);
			results_pending = probs_due.size();
		end
	end

endmodule

// ===== sim/tb_top.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top - testbench for the regret matching node
// Drives directed and random requests through the start/busy handshake in
// three pacing phases; rmn_checker predicts and checks the read results.
// ----------------------------------------------------------------------------
module tb_top;
	import rmn_pkg::*;

	localparam int ACTION_CNT     = ACTION_CNT_DEF;
	localparam int ITEMS_PER_PASS = 650;        // three pacing phases
	localparam int WATCHDOG_LIMIT = 2000;       // quiet cycles before giving up
	localparam int DRAIN_CYCLES   = 20 * ACTION_CNT + 16;

	logic                         clk;
	logic                         arst_n;
	logic                         start;
	logic                         busy;
	kind_t                        kind;
	logic [ACTION_W-1:0]          action;
	logic signed [REGRET_W-1:0]   regret;
	logic [PROB_W-1:0]            strategy_share;
	logic [PROB_W-1:0]            weight;
	logic                         strobe;
	logic [ACTION_W-1:0]          out_action;
	logic [PROB_W-1:0]            probability;
	logic                         last_of_run;
	int                           mismatch_count;
	int                           results_pending;
	int                           quiet_cycles = 0;

	regret_matching_node #(.ACTION_CNT(ACTION_CNT)) u_top (
		.clk            (clk),
		.arst_n         (arst_n),
		.start          (start),
		.busy           (busy),
		.kind           (kind),
		.action         (action),
		.regret         (regret),
		.strategy_share (strategy_share),
		.weight         (weight),
		.strobe         (strobe),
		.out_action     (out_action),
		.probability    (probability),
		.last_of_run    (last_of_run)
	);

	rmn_checker #(.ACTION_CNT(ACTION_CNT)) u_checker (
		.clk             (clk),
		.arst_n          (arst_n),
		.start           (start),
		.busy            (busy),
		.kind            (kind),
		.action          (action),
		.regret          (regret),
		.strategy_share  (strategy_share),
		.weight          (weight),
		.strobe          (strobe),
		.out_action      (out_action),
		.probability     (probability),
		.last_of_run     (last_of_run),
		.mismatch_count  (mismatch_count),
		.results_pending (results_pending)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	// Watchdog: any accepted request or result strobe counts as progress.
	// The longest honest quiet stretch is a read plus a sender gap, so the
	// limit is far above anything legal.
	always @(posedge clk) begin
		if ((start && !busy) || strobe)
			quiet_cycles <= 0;
		else
			quiet_cycles <= quiet_cycles + 1;
		if (quiet_cycles >= WATCHDOG_LIMIT) begin
			$display("Verification failed");
			$finish;
		end
	end

	// Issues one request from a falling edge and returns on the falling edge
	// after it was taken. start stays high between back-to-back requests so it
	// never gets two assignments in one step.
	task automatic send_request(input kind_t k, input logic [ACTION_W-1:0] act,
			input logic signed [REGRET_W-1:0] rg, input logic [PROB_W-1:0] share,
			input logic [PROB_W-1:0] wt, input int idle_pct);
		logic taken;

		if ($urandom_range(99) < idle_pct) begin
			start <= 1'b0;
			do
				@(negedge clk);
			while ($urandom_range(99) < idle_pct);
		end
		start <= 1'b1;
		kind <= k;
		action <= act;
		regret <= rg;
		strategy_share <= share;
		weight <= wt;
		do begin
			@(posedge clk);
			taken = !busy;
			@(negedge clk);
		end while (!taken);
	endtask

	// Random request. Regrets mix full-range, small and extreme values so the
	// sums drift across zero often (covers the no-positive-regret read).
	// Shares and weights sometimes exceed one to hit the clamp.
	task automatic send_random(input int idle_pct);
		kind_t                      k;
		logic signed [REGRET_W-1:0] rg;
		logic [PROB_W-1:0]          pick [2];
		int                         roll;

		roll = $urandom_range(99);
		if (roll < 35)
			k = KIND_ADD_REGRET;
		else if (roll < 70)
			k = KIND_ADD_STRATEGY;
		else if (roll < 85)
			k = KIND_READ_CURRENT;
		else
			k = KIND_READ_AVERAGE;

		roll = $urandom_range(99);
		if (roll < 50)
			rg = $urandom;
		else if (roll < 80)
			rg = $signed($urandom_range(8192)) - 4096;
		else
			case ($urandom_range(2))
				0: rg = 32'sh7FFF_FFFF;
				1: rg = 32'sh8000_0000;
				default: rg = '0;
			endcase

		for (int i = 0; i < 2; i++) begin
			roll = $urandom_range(99);
			if (roll < 60)
				pick[i] = PROB_W'($urandom_range(ONE_INT));
			else if (roll < 80)
				pick[i] = PROB_W'($urandom);
			else
				case ($urandom_range(2))
					0: pick[i] = '0;
					1: pick[i] = ONE_Q16;
					default: pick[i] = '1;
				endcase
		end

		send_request(k, ACTION_W'($urandom), rg, pick[0], pick[1], idle_pct);
	endtask

	initial begin
		int idle_pct;

		arst_n = 1'b0;
		start = 1'b0;
		kind = KIND_ADD_REGRET;
		action = '0;
		regret = '0;
		strategy_share = '0;
		weight = '0;
		repeat (6) @(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);

		// Directed: reads from reset give the uniform split, then extremes of
		// regret, a one-sided strategy, clamped share and weight, tiny values.
		send_request(KIND_READ_CURRENT, 1'b0, '0, '0, '0, 13);
		send_request(KIND_READ_AVERAGE, 1'b1, '0, '0, '0, 13);
		send_request(KIND_ADD_REGRET, 1'b0, 32'sh8000_0000, '0, '0, 13);
		send_request(KIND_READ_CURRENT, 1'b0, '0, '0, '0, 13);
		send_request(KIND_ADD_REGRET, 1'b1, 32'sh7FFF_FFFF, '0, '0, 13);
		send_request(KIND_READ_CURRENT, 1'b0, '0, '0, '0, 13);
		send_request(KIND_ADD_REGRET, 1'b0, 32'sh7FFF_FFFF, '0, '0, 13);
		send_request(KIND_READ_CURRENT, 1'b1, '0, '0, '0, 13);
		send_request(KIND_ADD_REGRET, 1'b0, 32'sh7FFF_FFFF, '0, '0, 13);
		send_request(KIND_READ_CURRENT, 1'b0, '0, '0, '0, 13);
		send_request(KIND_ADD_STRATEGY, 1'b0, '0, '0, ONE_Q16, 13);
		send_request(KIND_ADD_STRATEGY, 1'b1, '0, ONE_Q16, ONE_Q16, 13);
		send_request(KIND_READ_AVERAGE, 1'b0, '0, '0, '0, 13);
		send_request(KIND_ADD_STRATEGY, 1'b0, '0, '1, '1, 13);
		send_request(KIND_READ_AVERAGE, 1'b0, '0, '0, '0, 13);
		send_request(KIND_ADD_STRATEGY, 1'b1, '0, 17'd1, 17'd1, 13);
		send_request(KIND_ADD_STRATEGY, 1'b0, '0, 17'd65537, '0, 13);
		send_request(KIND_READ_AVERAGE, 1'b1, '0, '0, '0, 13);
		send_request(KIND_ADD_REGRET, 1'b1, 32'sh8000_0000, '0, '0, 13);
		send_request(KIND_ADD_REGRET, 1'b1, '0, '0, '0, 13);
		send_request(KIND_READ_CURRENT, 1'b0, '0, '0, '0, 13);
		send_request(KIND_ADD_REGRET, 1'b1, 32'sd1, '0, '0, 13);
		send_request(KIND_READ_CURRENT, 1'b0, '0, '0, '0, 13);

		// Random: light sender gaps, then heavy gaps, then back to back.
		for (int pass = 0; pass < 3; pass++) begin
			case (pass)
				0: idle_pct = 13;
				1: idle_pct = 63;
				default: idle_pct = 0;
			endcase
			for (int n = 0; n < ITEMS_PER_PASS; n++)
				send_random(idle_pct);
		end
		start <= 1'b0;

		// Let the last read drain, then give an update time to finish so any
		// stray strobe still gets flagged.
		while (results_pending != 0)
			@(negedge clk);
		repeat (DRAIN_CYCLES) @(negedge clk);

		if (mismatch_count == 0 && results_pending == 0)
			$display("Verification passed");
		else
			$display("Verification failed");
		$finish;
	end

endmodule
